@@ hw/rtl/luma_threshold_centroid_unit_defines.svh @@
// ============================================================================
// Assertion macros for the luma threshold centroid unit
// Short forms for clocked assertions on aclk, disabled while aresetn is low.
// ============================================================================
`ifndef LUMA_THRESHOLD_CENTROID_UNIT_DEFINES_SVH
`define LUMA_THRESHOLD_CENTROID_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the condition.
`define LTC_ASSERT_HOLDS(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the condition.
`define LTC_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ltc_pkg.sv @@
// ============================================================================
// ltc_pkg
// Types and constants shared by the luma threshold centroid unit.
// ============================================================================
package ltc_pkg;

    localparam int MAX_DIMENSION_DEF = 4096;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int CHAN_W      = 8;
    localparam int LUMA_W      = 8;
    localparam int WEIGHT_W    = 16;
    localparam int PROD_W      = 24;
    localparam int CFG_DIM_W   = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int FRAC_W      = 16;
    localparam int SUM_W       = 48;
    localparam int COUNT_W     = 25;
    localparam int QUEUE_DEPTH = 2;

    // Luma weights in 0.16 fixed point, standard R/G/B order.
    localparam logic [WEIGHT_W-1:0] WEIGHT_RED   = 16'd19595;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd38470;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE  = 16'd7471;

    localparam logic [CFG_INDEX_W-1:0] CFG_LUMA_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd2;

    localparam logic [LUMA_W-1:0]    THRESHOLD_RESET = 8'd215;
    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET     = 13'd640;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET    = 13'd480;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } ltc_pixel_t;

    typedef struct packed {
        logic              is_white;
        logic              frame_end;
        logic              object_found;
        logic [FRAC_W-1:0] centroid_x_frac;
        logic [FRAC_W-1:0] centroid_y_frac;
    } ltc_result_t;

    // One classified pixel; the sums are meaningful on a frame end only.
    typedef struct packed {
        logic               is_white;
        logic               frame_end;
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [COUNT_W-1:0] count;
    } ltc_entry_t;

endpackage

@@ hw/rtl/ltc_queue.sv @@
// ============================================================================
// ltc_queue
// Short queue of classified pixels between the front and the back end.
// ============================================================================
`include "luma_threshold_centroid_unit_defines.svh"

module ltc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ltc_pkg::ltc_entry_t push_entry,
    output logic               push_ready,
    input  logic               pop,
    output logic               head_valid,
    output ltc_pkg::ltc_entry_t head_entry
);
    import ltc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ltc_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `LTC_ASSERT_HOLDS(a_queue_bounded, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

@@ hw/rtl/ltc_serial_div.sv @@
// ============================================================================
// ltc_serial_div
// Restoring divider that produces one quotient bit per cycle.
// ============================================================================
`include "luma_threshold_centroid_unit_defines.svh"

module ltc_serial_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 25
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg, rem_reg, rem_next;
    logic [DEN_W:0]   trial, trial_diff;
    logic             qbit;

    // The remainder stays below the divisor, so one extra bit holds the trial.
    assign trial      = {rem_reg, num_reg[NUM_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign qbit       = (trial >= {1'b0, den_reg});
    assign rem_next   = qbit ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];

    assign done = done_reg;
    assign quot = num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    `LTC_ASSERT_HOLDS(a_div_start_idle, start, !busy_reg, "divider started while busy")

endmodule

@@ hw/rtl/ltc_front.sv @@
// ============================================================================
// ltc_front
// Accepts pixels, tracks raster position, thresholds luma and accumulates.
// ============================================================================
`include "luma_threshold_centroid_unit_defines.svh"

module ltc_front #(
    parameter int  MAX_DIMENSION = ltc_pkg::MAX_DIMENSION_DEF,
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  ltc_pkg::ltc_pixel_t      s_pixel,
    input  logic [ltc_pkg::LUMA_W-1:0] threshold,
    input  logic [DIM_W-1:0]         img_w,
    input  logic [DIM_W-1:0]         img_h,
    output logic                     q_push,
    output ltc_pkg::ltc_entry_t      q_entry,
    input  logic                     q_ready
);
    import ltc_pkg::*;

    localparam int POS_W = $clog2(MAX_DIMENSION);

    logic [POS_W-1:0]   col_reg, row_reg;
    logic               line_end, frame_end, s_fire;
    logic [PROD_W-1:0]  luma_sum;

    logic               a_valid_reg;
    logic [LUMA_W-1:0]  a_luma_reg;
    logic [POS_W-1:0]   a_col_reg, a_row_reg;
    logic               a_frame_end_reg;

    logic [SUM_W-1:0]   sum_x_reg, sum_y_reg, sum_x_next, sum_y_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               white;

    assign line_end  = (DIM_W'(col_reg) >= img_w - DIM_W'(1));
    assign frame_end = line_end && (DIM_W'(row_reg) >= img_h - DIM_W'(1));
    assign s_ready   = !a_valid_reg || q_ready;
    assign s_fire    = s_valid && s_ready;

    assign luma_sum = PROD_W'(WEIGHT_RED) * PROD_W'(s_pixel.red)
                    + PROD_W'(WEIGHT_GREEN) * PROD_W'(s_pixel.green)
                    + PROD_W'(WEIGHT_BLUE) * PROD_W'(s_pixel.blue);

    // Raster position and the first stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (s_fire) begin
                if (frame_end) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (line_end) begin
                    col_reg <= '0;
                    row_reg <= row_reg + POS_W'(1);
                end else begin
                    col_reg <= col_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_luma_reg      <= luma_sum[PROD_W-1 -: LUMA_W];
            a_col_reg       <= col_reg;
            a_row_reg       <= row_reg;
            a_frame_end_reg <= frame_end;
        end
    end

    // Second stage: threshold and accumulate as the pixel enters the queue.
    assign white  = (a_luma_reg >= threshold);
    assign q_push = a_valid_reg && q_ready;

    always_comb begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        count_next = count_reg;
        if (white) begin
            sum_x_next = sum_x_reg + SUM_W'(a_col_reg);
            sum_y_next = sum_y_reg + SUM_W'(a_row_reg);
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_comb begin
        q_entry.is_white  = white;
        q_entry.frame_end = a_frame_end_reg;
        q_entry.sum_x     = sum_x_next;
        q_entry.sum_y     = sum_y_next;
        q_entry.count     = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            count_reg <= '0;
        end else if (q_push) begin
            if (a_frame_end_reg) begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                count_reg <= '0;
            end else begin
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                count_reg <= count_next;
            end
        end
    end

    `LTC_ASSERT_NEXT(a_front_clear_after_frame, q_push && a_frame_end_reg, count_reg == '0, "accumulators not cleared after frame end")

endmodule

@@ hw/rtl/ltc_back.sv @@
// ============================================================================
// ltc_back
// Drains the queue, runs the centroid divisions and holds the result word.
// ============================================================================
`include "luma_threshold_centroid_unit_defines.svh"

module ltc_back #(
    parameter int  MAX_DIMENSION = ltc_pkg::MAX_DIMENSION_DEF,
    parameter int  FRACTION_BITS = ltc_pkg::FRACTION_BITS_DEF,
    localparam int DIM_W         = $clog2(MAX_DIMENSION + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  ltc_pkg::ltc_entry_t q_entry,
    output logic                q_pop,
    input  logic [DIM_W-1:0]    img_w,
    input  logic [DIM_W-1:0]    img_h,
    output logic                m_valid,
    input  logic                m_ready,
    output ltc_pkg::ltc_result_t m_result
);
    import ltc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MEAN_X = 3'd1;
    localparam logic [2:0] ST_FRAC_X = 3'd2;
    localparam logic [2:0] ST_MEAN_Y = 3'd3;
    localparam logic [2:0] ST_FRAC_Y = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam logic [FRAC_W-1:0] FRAC_FULL = (FRACTION_BITS >= FRAC_W) ? '1 :
                                              FRAC_W'((1 << FRACTION_BITS) - 1);

    logic [2:0]         state_reg, state_next;
    logic               white_reg, white_next;
    logic [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FRAC_W-1:0]  frac_x_reg, frac_x_next, frac_y_reg, frac_y_next;

    logic               m_valid_reg;
    ltc_result_t        m_result_reg, out_next;
    logic               out_free, load_out;

    logic               div_start, div_done;
    logic [SUM_W-1:0]   div_num, div_quot;
    logic [COUNT_W-1:0] div_den;

    ltc_serial_div #(
        .NUM_W(SUM_W),
        .DEN_W(COUNT_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .numer  (div_num),
        .denom  (div_den),
        .done   (div_done),
        .quot   (div_quot)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    always_comb begin
        state_next  = state_reg;
        white_next  = white_reg;
        sum_y_next  = sum_y_reg;
        count_next  = count_reg;
        frac_x_next = frac_x_reg;
        frac_y_next = frac_y_reg;
        q_pop       = 1'b0;
        load_out    = 1'b0;
        out_next    = '0;
        div_start   = 1'b0;
        div_num     = div_quot << FRACTION_BITS;
        div_den     = COUNT_W'(img_w);
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_entry.frame_end && (q_entry.count != '0)) begin
                        white_next = q_entry.is_white;
                        sum_y_next = q_entry.sum_y;
                        count_next = q_entry.count;
                        div_start  = 1'b1;
                        div_num    = q_entry.sum_x;
                        div_den    = q_entry.count;
                        state_next = ST_MEAN_X;
                    end else begin
                        load_out           = 1'b1;
                        out_next.is_white  = q_entry.is_white;
                        out_next.frame_end = q_entry.frame_end;
                    end
                end
            end
            ST_MEAN_X: begin
                if (div_done) begin
                    div_start = 1'b1;
                    if (div_quot >= SUM_W'(img_w)) begin
                        frac_x_next = FRAC_FULL;
                        div_num     = sum_y_reg;
                        div_den     = count_reg;
                        state_next  = ST_MEAN_Y;
                    end else begin
                        state_next = ST_FRAC_X;
                    end
                end
            end
            ST_FRAC_X: begin
                if (div_done) begin
                    frac_x_next = div_quot[FRAC_W-1:0];
                    div_start   = 1'b1;
                    div_num     = sum_y_reg;
                    div_den     = count_reg;
                    state_next  = ST_MEAN_Y;
                end
            end
            ST_MEAN_Y: begin
                div_den = COUNT_W'(img_h);
                if (div_done) begin
                    if (div_quot >= SUM_W'(img_h)) begin
                        frac_y_next = FRAC_FULL;
                        state_next  = ST_OUT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_FRAC_Y;
                    end
                end
            end
            ST_FRAC_Y: begin
                if (div_done) begin
                    frac_y_next = div_quot[FRAC_W-1:0];
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    load_out                 = 1'b1;
                    out_next.is_white        = white_reg;
                    out_next.frame_end       = 1'b1;
                    out_next.object_found    = 1'b1;
                    out_next.centroid_x_frac = frac_x_reg;
                    out_next.centroid_y_frac = frac_y_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        white_reg  <= white_next;
        sum_y_reg  <= sum_y_next;
        count_reg  <= count_next;
        frac_x_reg <= frac_x_next;
        frac_y_reg <= frac_y_next;
        if (load_out) begin
            m_result_reg <= out_next;
        end
    end

    `LTC_ASSERT_HOLDS(a_back_found_at_end, m_valid_reg && m_result_reg.object_found, m_result_reg.frame_end, "object flag outside a frame end")

endmodule

@@ hw/rtl/luma_threshold_centroid_unit.sv @@
// ============================================================================
// luma_threshold_centroid_unit
// Thresholds a raster pixel stream on luma and reports the white centroid.
// ============================================================================
//
//  channel   ports                            word
//  -------   -------------------------------  ---------------------------------
//  config    cfg_valid/cfg_ready/cfg_index    register write, cfg_data value
//  input     s_valid/s_ready/s_pixel          one pixel, blue/green/red
//  output    m_valid/m_ready/m_result         one classified pixel word
//
// Pixels that do not close a frame, and frame ends of empty frames, pass the
// input stage register, the queue and the output register at one word per
// clock while the output is not stalled. A frame end with white pixels holds
// the back end while up to four divisions share one serial divider that yields
// one quotient bit per clock; the queue keeps taking pixels meanwhile until full.
// Reset is synchronous and active low; configuration resets to threshold 215
// and a 640 by 480 frame, and writes are always accepted.
// A stalled output holds its word while the front end keeps filling the queue.
//
module luma_threshold_centroid_unit #(
    parameter int MAX_DIMENSION = ltc_pkg::MAX_DIMENSION_DEF,
    parameter int FRACTION_BITS = ltc_pkg::FRACTION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ltc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ltc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ltc_pkg::ltc_pixel_t              s_pixel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ltc_pkg::ltc_result_t             m_result
);
    import ltc_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

    logic [LUMA_W-1:0]    threshold_reg;
    logic [CFG_DIM_W-1:0] width_cfg_reg, height_cfg_reg;
    logic [DIM_W-1:0]     img_w, img_h;

    logic                 q_push, q_ready, q_pop, q_valid;
    ltc_entry_t           q_in_entry, q_head_entry;

    // A dimension of zero counts as one; a value beyond the maximum is clamped to it.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (32'(d) > 32'(MAX_DIMENSION)) begin
            r = DIM_W'(MAX_DIMENSION);
        end else begin
            r = DIM_W'(d);
        end
        return r;
    endfunction

    assign img_w     = clamp_dim(width_cfg_reg);
    assign img_h     = clamp_dim(height_cfg_reg);
    assign cfg_ready = 1'b1;

    // Register writes to an index outside the map are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RESET;
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LUMA_THRESHOLD: begin
                    threshold_reg <= cfg_data[LUMA_W-1:0];
                end
                CFG_IMAGE_WIDTH: begin
                    width_cfg_reg <= cfg_data[CFG_DIM_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    height_cfg_reg <= cfg_data[CFG_DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The front end classifies each pixel and snapshots the sums at frame end.
    ltc_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_pixel  (s_pixel),
        .threshold(threshold_reg),
        .img_w    (img_w),
        .img_h    (img_h),
        .q_push   (q_push),
        .q_entry  (q_in_entry),
        .q_ready  (q_ready)
    );

    // The queue lets the front end run on while the divider is busy.
    ltc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(q_in_entry),
        .push_ready(q_ready),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_entry(q_head_entry)
    );

    // The back end turns sums into Q0.16 fractions and drives the output word.
    ltc_back #(
        .MAX_DIMENSION(MAX_DIMENSION),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_head_entry),
        .q_pop   (q_pop),
        .img_w   (img_w),
        .img_h   (img_h),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_result(m_result)
    );

endmodule
